FILE: hw/rtl/frustum_box_classify_defines.svh
// Assertion macros used by the frustum box classifier checker
`ifndef FRUSTUM_BOX_CLASSIFY_DEFINES_SVH
`define FRUSTUM_BOX_CLASSIFY_DEFINES_SVH

// check a same-cycle implication
`define FBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum_box_classify: same-cycle check failed");

// check an implication in the following cycle
`define FBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum_box_classify: next-cycle check failed");

`endif

FILE: hw/rtl/fbc_pkg.sv
// Shared types and constants of the frustum box classifier
package fbc_pkg;

    localparam int NUM_PLANE_REGS = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PLANE_BITS     = 64;
    localparam int FIELD_BITS     = 16;
    localparam int COEF_BITS      = 16;
    localparam int MARGIN_BITS    = 16;
    localparam int D_SHIFT        = 14;
    localparam int CORNER_COUNT   = 8;
    localparam int AXES           = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_PLANE_BASE = 3'd0;
    localparam cfg_index_t REG_MARGIN     = 3'd6;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INSIDE    = 2'd1,
        VERDICT_INTERSECT = 2'd2
    } verdict_t;

    typedef struct packed {
        logic valid;
        logic outside;
        logic all_in;
    } fbc_flags_t;

endpackage

FILE: hw/rtl/fbc_ifs.sv
// Channel interfaces of the frustum box classifier
interface fbc_box_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface fbc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

interface fbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/frustum_box_classify.sv
// Frustum box classifier top level: config registers, plane cell chain, result register
//
// Classifies one axis-aligned box per cycle against the first PLANE_COUNT
// configured planes: verdict 0 outside, 1 inside, 2 intersecting. Each plane
// has a cell of two register stages (six multiplies, then eight corner sums
// with their margin compares), and the boxes march down the chain of cells, so
// a box passes through the 2*PLANE_COUNT cell stages and then the result
// register before its verdict becomes valid, and a new box is
// taken every cycle. The whole chain advances together; it holds only while a
// finished verdict waits on the result channel. Configuration writes are always
// accepted, take effect on the next cycle, and must be issued while the chain
// is empty.
module frustum_box_classify #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    fbc_cfg_if.sink       cfg,
    fbc_box_if.sink       box,
    fbc_result_if.source  res
);
    import fbc_pkg::*;

    logic [PLANE_BITS-1:0]        planes [PLANE_COUNT];
    logic [MARGIN_BITS-1:0]       margin;
    logic                         advance;
    fbc_flags_t                   flags_chain [PLANE_COUNT+1];
    logic signed [COORD_BITS-1:0] lo_chain    [PLANE_COUNT+1][AXES];
    logic signed [COORD_BITS-1:0] hi_chain    [PLANE_COUNT+1][AXES];
    logic                         res_valid_reg;
    verdict_t                     verdict_reg;
    verdict_t                     verdict_next;
    fbc_flags_t                   last_flags;

    fbc_cfg_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .planes (planes),
        .margin (margin)
    );

    assign advance   = !res_valid_reg || res.ready;
    assign box.ready = advance;

    always_comb
    begin
        flags_chain[0].valid   = box.valid;
        flags_chain[0].outside = 1'b0;
        flags_chain[0].all_in  = 1'b1;
        lo_chain[0][0] = box.box_min_x;
        lo_chain[0][1] = box.box_min_y;
        lo_chain[0][2] = box.box_min_z;
        hi_chain[0][0] = box.box_max_x;
        hi_chain[0][1] = box.box_max_y;
        hi_chain[0][2] = box.box_max_z;
    end

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_cell
        fbc_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .plane     (planes[p]),
            .margin    (margin),
            .flags_in  (flags_chain[p]),
            .lo_in     (lo_chain[p]),
            .hi_in     (hi_chain[p]),
            .flags_out (flags_chain[p+1]),
            .lo_out    (lo_chain[p+1]),
            .hi_out    (hi_chain[p+1])
        );
    end

    always_comb
    begin
        last_flags = flags_chain[PLANE_COUNT];
        priority if (last_flags.outside)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (last_flags.all_in)
        begin
            verdict_next = VERDICT_INSIDE;
        end
        else
        begin
            verdict_next = VERDICT_INTERSECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= last_flags.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.verdict = verdict_reg;

endmodule

FILE: hw/rtl/fbc_cfg_regs.sv
// Plane and margin configuration registers
module fbc_cfg_regs #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    fbc_cfg_if.sink                                       cfg,
    output logic [fbc_pkg::PLANE_BITS-1:0]                planes [PLANE_COUNT],
    output logic [fbc_pkg::MARGIN_BITS-1:0]               margin
);
    import fbc_pkg::*;

    logic [PLANE_BITS-1:0]  plane_reg [PLANE_COUNT];
    logic [MARGIN_BITS-1:0] margin_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= '0;
            end
            margin_reg <= '0;
        end
        else if (cfg.valid)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                if (cfg.index == REG_PLANE_BASE + CFG_INDEX_BITS'(p))
                begin
                    plane_reg[p] <= cfg.data;
                end
            end
            if (cfg.index == REG_MARGIN)
            begin
                margin_reg <= cfg.data[MARGIN_BITS-1:0];
            end
        end
    end

    assign planes = plane_reg;
    assign margin = margin_reg;

endmodule

FILE: hw/rtl/fbc_cell.sv
// One plane cell: corner products, corner distances and running verdict flags
module fbc_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [fbc_pkg::PLANE_BITS-1:0]    plane,
    input  logic [fbc_pkg::MARGIN_BITS-1:0]   margin,
    input  fbc_pkg::fbc_flags_t               flags_in,
    input  logic signed [COORD_BITS-1:0]      lo_in  [3],
    input  logic signed [COORD_BITS-1:0]      hi_in  [3],
    output fbc_pkg::fbc_flags_t               flags_out,
    output logic signed [COORD_BITS-1:0]      lo_out [3],
    output logic signed [COORD_BITS-1:0]      hi_out [3]
);
    import fbc_pkg::*;

    localparam int PW  = COORD_BITS + COEF_BITS;
    localparam int DW  = FIELD_BITS + D_SHIFT;
    localparam int SW  = ((PW > DW) ? PW : DW) + 2;

    logic signed [COEF_BITS-1:0]  coef [AXES];
    logic signed [FIELD_BITS-1:0] d_off;

    logic signed [PW-1:0]         prod_lo_next [AXES];
    logic signed [PW-1:0]         prod_hi_next [AXES];
    logic signed [PW-1:0]         prod_lo_reg  [AXES];
    logic signed [PW-1:0]         prod_hi_reg  [AXES];
    logic signed [COORD_BITS-1:0] lo_a_reg     [AXES];
    logic signed [COORD_BITS-1:0] hi_a_reg     [AXES];
    logic signed [COORD_BITS-1:0] lo_b_reg     [AXES];
    logic signed [COORD_BITS-1:0] hi_b_reg     [AXES];
    fbc_flags_t                   flags_a_reg;
    fbc_flags_t                   flags_b_reg;
    fbc_flags_t                   flags_b_next;

    logic signed [SW-1:0]         corner_dist [CORNER_COUNT];
    logic signed [SW-1:0]         d_term;
    logic signed [SW-1:0]         margin_term;
    logic [CORNER_COUNT-1:0]      above;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            coef[i]         = plane[i*FIELD_BITS +: FIELD_BITS];
            prod_lo_next[i] = PW'(coef[i]) * PW'(lo_in[i]);
            prod_hi_next[i] = PW'(coef[i]) * PW'(hi_in[i]);
        end
        d_off = plane[AXES*FIELD_BITS +: FIELD_BITS];
    end

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_a_reg <= '0;
        end
        else if (advance)
        begin
            flags_a_reg <= flags_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            lo_a_reg    <= lo_in;
            hi_a_reg    <= hi_in;
        end
    end

    // distance stage
    always_comb
    begin
        d_term      = SW'(d_off) <<< D_SHIFT;
        margin_term = SW'($signed({1'b0, margin}));
        for (int k = 0; k < CORNER_COUNT; k++)
        begin
            corner_dist[k] = SW'(((k & 1) != 0) ? prod_hi_reg[0] : prod_lo_reg[0])
                           + SW'(((k & 2) != 0) ? prod_hi_reg[1] : prod_lo_reg[1])
                           + SW'(((k & 4) != 0) ? prod_hi_reg[2] : prod_lo_reg[2])
                           + d_term;
            above[k] = corner_dist[k] > margin_term;
        end
        flags_b_next.valid   = flags_a_reg.valid;
        flags_b_next.outside = flags_a_reg.outside | ~(|above);
        flags_b_next.all_in  = flags_a_reg.all_in & (&above);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_b_reg <= '0;
        end
        else if (advance)
        begin
            flags_b_reg <= flags_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_b_reg <= lo_a_reg;
            hi_b_reg <= hi_a_reg;
        end
    end

    assign flags_out = flags_b_reg;
    assign lo_out    = lo_b_reg;
    assign hi_out    = hi_b_reg;

endmodule

FILE: hw/rtl/fbc_checker.sv
// Port-level checker of the frustum box classifier and its bind
`include "frustum_box_classify_defines.svh"

module fbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_ready,
    input logic       box_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] verdict
);
    // box side stalls exactly when a verdict waits unclaimed
    `FBC_ASSERT_NOW(a_box_ready_tracks_res, 1'b1, box_ready == (!res_valid || res_ready))
    // config port never stalls
    `FBC_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)
    // a waiting verdict holds
    `FBC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(verdict))

endmodule

bind frustum_box_classify fbc_checker u_fbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg.ready),
    .box_ready (box.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .verdict   (res.verdict)
);

FILE: tb/tb_frustum_box_classify.sv
// Self-checking testbench for the frustum box classifier: random and directed boxes, checked verdicts
module tb_frustum_box_classify;
    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_BITS  = 16;
    localparam int DRAIN_CYCLES = 2 * PLANE_COUNT + 4;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BOXES = 125;
    localparam int ONE_Q14 = 16384;
    localparam cfg_index_t REG_UNUSED = 3'd7;

    typedef struct {
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_min_z;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_max_y;
        logic signed [COORD_BITS-1:0] box_max_z;
    } box_t;

    class verdict_board;
        logic [PLANE_BITS-1:0]  planes [NUM_PLANE_REGS];
        logic [MARGIN_BITS-1:0] margin;
        verdict_t pending_verdicts [$];
        int errors;
        int seen [3];

        function new();
            foreach (planes[i])
                planes[i] = '0;
            margin = '0;
            errors = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [63:0] data);
            if (idx < NUM_PLANE_REGS)
                planes[idx] = data;
            else if (idx == REG_MARGIN)
                margin = data[MARGIN_BITS-1:0];
        endfunction

        function verdict_t classify_box(box_t b);
            longint lo [3];
            longint hi [3];
            longint a, bn, c, d, x, y, z, corner_dist, m;
            int above;
            int all_in;
            lo[0] = b.box_min_x;
            lo[1] = b.box_min_y;
            lo[2] = b.box_min_z;
            hi[0] = b.box_max_x;
            hi[1] = b.box_max_y;
            hi[2] = b.box_max_z;
            m = {48'd0, margin};
            all_in = 0;
            for (int p = 0; p < PLANE_COUNT && p < NUM_PLANE_REGS; p++)
            begin
                a  = $signed(planes[p][15:0]);
                bn = $signed(planes[p][31:16]);
                c  = $signed(planes[p][47:32]);
                d  = $signed(planes[p][63:48]);
                above = 0;
                for (int k = 0; k < CORNER_COUNT; k++)
                begin
                    x = k[0] ? hi[0] : lo[0];
                    y = k[1] ? hi[1] : lo[1];
                    z = k[2] ? hi[2] : lo[2];
                    corner_dist = a * x + bn * y + c * z + d * ONE_Q14;
                    if (corner_dist > m)
                        above++;
                end
                if (above == 0)
                    return VERDICT_OUTSIDE;
                if (above == CORNER_COUNT)
                    all_in++;
            end
            return (all_in == PLANE_COUNT) ? VERDICT_INSIDE : VERDICT_INTERSECT;
        endfunction

        function void note_box(box_t b);
            pending_verdicts.push_back(classify_box(b));
        endfunction

        function void check_verdict(logic [1:0] got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: verdict with none expected, expected none, got %0d",
                         $time, got);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            seen[want]++;
            if (got !== want)
            begin
                $display("%0t: verdict mismatch, expected %0d (%s), got %0d",
                         $time, want, want.name(), got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic idle_on;
    int   n_boxes;
    int   n_settings;
    logic [PLANE_BITS-1:0] next_planes [NUM_PLANE_REGS];
    verdict_board sb;

    fbc_box_if #(.COORD_BITS(COORD_BITS)) box_ch();
    fbc_result_if res_ch();
    fbc_cfg_if    cfg_ch();

    frustum_box_classify #(
        .PLANE_COUNT(PLANE_COUNT),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .box  (box_ch),
        .res  (res_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("tb_frustum_box_classify: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
            sb.check_verdict(res_ch.verdict);
    end

    // stall the result side in random bursts
    initial
    begin
        forever
        begin
            if (idle_on === 1'b1 && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic box_t corners(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t b;
        b.box_min_x = 16'(lx);
        b.box_min_y = 16'(ly);
        b.box_min_z = 16'(lz);
        b.box_max_x = 16'(hx);
        b.box_max_y = 16'(hy);
        b.box_max_z = 16'(hz);
        return b;
    endfunction

    function automatic box_t cube(int lo, int hi);
        return corners(lo, lo, lo, hi, hi, hi);
    endfunction

    function automatic box_t make_box(int span);
        int lo [3];
        int hi [3];
        int ctr, half, t, r;
        r = $urandom_range(0, 99);
        for (int j = 0; j < 3; j++)
        begin
            if (r < 15)
            begin
                lo[j] = $signed(16'($urandom));
                hi[j] = $signed(16'($urandom));
            end
            else if (r < 25)
            begin
                lo[j] = $signed(pick_field());
                hi[j] = $signed(pick_field());
            end
            else
            begin
                ctr  = int'($urandom_range(0, 3 * span)) - 3 * span / 2;
                half = $urandom_range(0, span / 2);
                lo[j] = clamp16(ctr - half);
                hi[j] = clamp16(ctr + half);
                if ($urandom_range(0, 19) == 0)
                begin
                    t = lo[j];
                    lo[j] = hi[j];
                    hi[j] = t;
                end
            end
        end
        return corners(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // slab planes: near +z, far -z, top -y, bottom +y, left +x, right -x
    function automatic void build_slab(int k, int jitter);
        int axis_of [6] = '{2, 2, 1, 1, 0, 0};
        int sign_of [6] = '{1, -1, -1, 1, 1, -1};
        int comp [3];
        for (int p = 0; p < NUM_PLANE_REGS; p++)
        begin
            for (int j = 0; j < 3; j++)
                comp[j] = (j == axis_of[p]) ? sign_of[p] * ONE_Q14
                        : int'($urandom_range(0, 2 * jitter)) - jitter;
            next_planes[p] = {16'(k), 16'(comp[2]), 16'(comp[1]), 16'(comp[0])};
        end
    endfunction

    function automatic void build_random_planes();
        for (int p = 0; p < NUM_PLANE_REGS; p++)
            next_planes[p] = {pick_field(), pick_field(), pick_field(), pick_field()};
    endfunction

    task automatic wait_idle();
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_regs(logic [MARGIN_BITS-1:0] m);
        wait_idle();
        for (int p = 0; p < NUM_PLANE_REGS; p++)
            write_cfg(REG_PLANE_BASE + cfg_index_t'(p), next_planes[p]);
        write_cfg(REG_MARGIN, {$urandom, 16'($urandom), m});
        write_cfg(REG_UNUSED, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
        n_settings++;
        repeat (2) @(posedge clk);
    endtask

    task automatic send_box(box_t b);
        box_ch.valid     <= 1'b1;
        box_ch.box_min_x <= b.box_min_x;
        box_ch.box_min_y <= b.box_min_y;
        box_ch.box_min_z <= b.box_min_z;
        box_ch.box_max_x <= b.box_max_x;
        box_ch.box_max_y <= b.box_max_y;
        box_ch.box_max_z <= b.box_max_z;
        @(posedge clk);
        while (!box_ch.ready)
            @(posedge clk);
        sb.note_box(b);
        n_boxes++;
    endtask

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            box_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    initial
    begin
        int k;
        logic [MARGIN_BITS-1:0] m;
        sb = new();
        n_boxes = 0;
        n_settings = 0;
        idle_on <= 1'b1;
        rst_n <= 1'b0;
        box_ch.valid     <= 1'b0;
        box_ch.box_min_x <= '0;
        box_ch.box_min_y <= '0;
        box_ch.box_min_z <= '0;
        box_ch.box_max_x <= '0;
        box_ch.box_max_y <= '0;
        box_ch.box_max_z <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers straight out of reset: every box is outside
        send_box(cube(-32768, 32767));
        send_box(cube(0, 0));
        send_box(cube(32767, -32768));
        send_box(cube(21845, -21846));
        send_box(cube(-21846, 21845));
        box_ch.valid <= 1'b0;

        build_slab(1000, 0);
        load_regs(16'h0000);
        send_box(cube(-10, 10));
        send_box(corners(5000, 0, 0, 6000, 0, 0));
        send_box(cube(-2000, 2000));
        send_box(cube(10, -10));
        send_box(cube(2000, -2000));
        send_box(cube(-1000, -1000));
        send_box(cube(-999, 999));
        send_box(cube(-1000, 1000));
        send_box(cube(-32768, 32767));
        box_ch.valid <= 1'b0;

        // widest margin shifts the boundary inward by just under four units
        load_regs(16'hFFFF);
        send_box(cube(-996, 996));
        send_box(cube(-997, 997));
        send_box(cube(-10, 10));
        box_ch.valid <= 1'b0;

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            k = $urandom_range(256, 20000);
            case (ph)
                0:       begin build_slab(k, 0);      m = 16'h0000; end
                1:       begin build_slab(k, 2000);   m = 16'hFFFF; end
                2:       begin build_random_planes(); m = 16'($urandom); k = 20000; end
                3:       begin build_slab(k, 500);    m = 16'($urandom); end
                4:       begin k = 32767; build_slab(k, 0); m = 16'h0000; end
                5:       begin build_random_planes(); m = pick_field(); k = 30000; end
                6:       begin build_slab(k, 4000);   m = 16'($urandom); end
                default: begin build_slab(k, 100);    m = 16'h0000; end
            endcase
            load_regs(m);
            idle_on <= (ph != RAND_PHASES - 1);
            for (int n = 0; n < PHASE_BOXES; n++)
            begin
                send_box(make_box(k));
                idle_gap();
            end
            box_ch.valid <= 1'b0;
        end

        wait_idle();
        if (sb.pending_verdicts.size() != 0)
            sb.errors++;
        $display("Classified %0d boxes under %0d register settings, including reset values.",
                 n_boxes, n_settings);
        $display("Verdicts seen: %0d outside, %0d inside, %0d intersecting; %0d errors.",
                 sb.seen[VERDICT_OUTSIDE], sb.seen[VERDICT_INSIDE],
                 sb.seen[VERDICT_INTERSECT], sb.errors);
        if (sb.errors == 0)
            $display("tb_frustum_box_classify: clean");
        else
            $display("tb_frustum_box_classify: errors");
        $finish;
    end

endmodule
